// File: rtl/pls_pkg.sv
// Package with the shared types, codes and constants of the positional list store.
`default_nettype none

package pls_pkg;

    // Default number of list entries.
    localparam int PLS_CAPACITY = 64;

    // Field widths of the command and result transfers.
    localparam int FUNC_W   = 4;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Command codes.
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AT    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_RD_FRONT  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_RD_BACK   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_RD_AT     = 4'd5;
    localparam logic [FUNC_W-1:0] FN_RM_FRONT  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_RM_BACK   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_RM_AT     = 4'd8;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT,
        S_DRAIN,
        S_WRITE_NEW,
        S_FINISH
    } pls_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup_up;
        logic setup_dn;
        logic step;
        logic clear_pend;
        logic rd_where;
        logic write_new;
        logic emit;
    } pls_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_ins;
        logic is_rd;
        logic op_ok;
        logic no_shift;
        logic at_end;
        logic out_free;
    } pls_stat_t;

endpackage

`default_nettype wire

// File: rtl/pls_ctrl.sv
// Controller state machine of the positional list store.
`default_nettype none

module pls_ctrl
    import pls_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire pls_stat_t stat,
    output pls_cmd_t       cmd
);

    pls_state_t state_reg;
    pls_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!stat.op_ok) begin
                    state_next = S_FINISH;
                end else if (stat.is_rd) begin
                    cmd.rd_where = 1'b1;
                    state_next   = S_FINISH;
                end else if (stat.is_ins) begin
                    if (stat.no_shift) begin
                        state_next = S_WRITE_NEW;
                    end else begin
                        cmd.setup_up = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end else begin
                    if (stat.no_shift) begin
                        state_next = S_FINISH;
                    end else begin
                        cmd.setup_dn = 1'b1;
                        state_next   = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                cmd.step = 1'b1;
                if (stat.at_end) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last moved element is written in this cycle.
                cmd.clear_pend = 1'b1;
                state_next     = stat.is_ins ? S_WRITE_NEW : S_FINISH;
            end
            S_WRITE_NEW: begin
                cmd.write_new = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/pls_dp.sv
// Datapath of the positional list store: element memory, shift engine and result register.
`default_nettype none

module pls_dp
    import pls_pkg::*;
#(
    parameter int CAPACITY = PLS_CAPACITY
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic [FUNC_W+POS_W+DATA_W-1:0]        s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic [DATA_W+STATUS_W+COUNT_W+6:0]         m_tdata,
    input  wire pls_cmd_t                              cmd,
    output pls_stat_t                                  stat
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int OW   = DATA_W + STATUS_W + COUNT_W + 7;

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [FUNC_W-1:0] func_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] value_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [AW-1:0]     ptr_reg;
    logic [AW-1:0]     end_reg;
    logic              dir_up_reg;
    logic [AW-1:0]     wr_addr_reg;
    logic              wr_pend_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              m_tvalid_reg;
    logic [OW-1:0]     m_tdata_reg;

    logic              is_ins;
    logic              is_rd;
    logic              is_rm;
    logic [CMPW-1:0]   cnt_w;
    logic [CMPW-1:0]   last_w;
    logic [CMPW-1:0]   where_w;
    logic [STATUS_W-1:0] status;
    logic              op_ok;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] read_value;
    logic [CMPW-1:0]   cnt_out_w;

    // Command classes.
    always_comb begin
        is_ins = (func_reg == FN_INS_FRONT) || (func_reg == FN_INS_BACK) ||
                 (func_reg == FN_INS_AT);
        is_rd  = (func_reg == FN_RD_FRONT) || (func_reg == FN_RD_BACK) ||
                 (func_reg == FN_RD_AT);
        is_rm  = (func_reg == FN_RM_FRONT) || (func_reg == FN_RM_BACK) ||
                 (func_reg == FN_RM_AT);
    end

    // Target position of the latched command.
    always_comb begin
        cnt_w  = CMPW'(count_reg);
        last_w = (count_reg == '0) ? '0 : cnt_w - CMPW'(1);
        case (func_reg)
            FN_INS_FRONT, FN_RD_FRONT, FN_RM_FRONT: where_w = '0;
            FN_INS_BACK:                            where_w = cnt_w;
            FN_RD_BACK, FN_RM_BACK:                 where_w = last_w;
            default:                                where_w = CMPW'(pos_reg);
        endcase
    end

    // Status of the latched command against the current count.
    always_comb begin
        status = ST_OK;
        if (is_ins) begin
            if (where_w > cnt_w) begin
                status = ST_BADPOS;
            end else if (cnt_w >= CMPW'(CAPACITY)) begin
                status = ST_FULL;
            end
        end else if (is_rd || is_rm) begin
            if (count_reg == '0) begin
                status = ST_EMPTY;
            end else if (where_w >= cnt_w) begin
                status = ST_BADPOS;
            end
        end
        op_ok = (status == ST_OK) && (is_ins || is_rd || is_rm);
    end

    // Status to the controller.
    always_comb begin
        stat.is_ins   = is_ins;
        stat.is_rd    = is_rd;
        stat.op_ok    = op_ok;
        stat.no_shift = is_ins ? (where_w == cnt_w) : (where_w == last_w);
        stat.at_end   = (ptr_reg == end_reg);
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    // Command latch.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tdata[FUNC_W-1:0];
            pos_reg   <= s_tdata[FUNC_W+POS_W-1:FUNC_W];
            value_reg <= s_tdata[FUNC_W+POS_W+DATA_W-1:FUNC_W+POS_W];
        end
    end

    // Shift pointers: each step reads one element and schedules its move by one place.
    always_ff @(posedge aclk) begin
        if (cmd.setup_up) begin
            ptr_reg    <= AW'(last_w);
            end_reg    <= AW'(where_w);
            dir_up_reg <= 1'b1;
        end else if (cmd.setup_dn) begin
            ptr_reg    <= AW'(where_w + CMPW'(1));
            end_reg    <= AW'(last_w);
            dir_up_reg <= 1'b0;
        end else if (cmd.step) begin
            ptr_reg     <= dir_up_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
            wr_addr_reg <= dir_up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
        end
    end

    // Pending write of the element read in the previous cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else if (cmd.step) begin
            wr_pend_reg <= 1'b1;
        end else if (cmd.clear_pend) begin
            wr_pend_reg <= 1'b0;
        end
    end

    assign rd_addr = cmd.rd_where ? AW'(where_w) : ptr_reg;

    // Element memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= rdata_reg;
        end else if (cmd.write_new) begin
            mem[AW'(where_w)] <= value_reg;
        end
        // Read data is held between reads so a stalled result keeps its value.
        if (cmd.rd_where || cmd.step) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Count after the command.
    always_comb begin
        count_next = count_reg;
        if (op_ok && is_ins) begin
            count_next = count_reg + CW'(1);
        end else if (op_ok && is_rm) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.emit) begin
            count_reg <= count_next;
        end
    end

    // Result fields.
    always_comb begin
        if (is_rd) begin
            read_value = op_ok ? rdata_reg : '1;
        end else begin
            read_value = '0;
        end
        cnt_out_w = CMPW'(count_next);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {7'd0, cnt_out_w[COUNT_W-1:0], status, read_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // The element count never passes the capacity.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    // A shifted element and the new value are never written in the same cycle.
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_pend_reg && cmd.write_new))
        else $error("two memory writes in one cycle");

    // A result is loaded only when the output register is free.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrites a pending transfer");

    // The count moves by at most one per command.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg == $past(count_reg) - CW'(1))))
        else $error("count changed by more than one");
`endif

endmodule

`default_nettype wire

// File: rtl/positional_list_store_top.sv
// Top level of the positional list store.
//
// An ordered list of up to CAPACITY signed 32-bit elements driven by commands.
// The s_ channel carries one command per transfer: insert, read or remove at
// the front, the back or a given position. The m_ channel returns one result
// per command: the value read (-1 on a failed read, 0 for other commands),
// a status code and the element count after the command.
// A read, a failing command, an unused code or a remove at the back goes
// straight from decode to the result; an insert at the back first writes the
// new value. An insert or remove that moves elements steps through them in a
// shift pass and a drain step, and an insert then writes the new value: the
// elements move one per cycle through the single write port of the element
// memory. m_tvalid rises as the block returns to idle. One command is
// processed at a time; s_tready is high only while idle, so a new command
// follows once the previous one is finished. A finished result sits in the
// output register, so the next command is taken while the previous result
// waits; if the receiver stalls, that next command completes its work and
// then holds until the output register frees. Reset empties the list at once
// (no clearing pass) and drops any result.
`default_nettype none

module positional_list_store_top
    import pls_pkg::*;
#(
    parameter int CAPACITY = PLS_CAPACITY
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func [3:0], position [10:4], value [42:11], zero fill [47:43]
    input  wire logic [47:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value [31:0], status [33:32], count [40:34], zero fill [47:41]
    output logic [47:0]      m_tdata
);

    pls_cmd_t  cmd;
    pls_stat_t stat;

    // Controller.
    pls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath.
    pls_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata[FUNC_W+POS_W+DATA_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

`default_nettype wire

// File: verif/tb_positional_list_store_top.sv
// Self-checking testbench for the positional list store: directed table, random command mix.
`default_nettype none

module tb_positional_list_store_top;
    import pls_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = PLS_CAPACITY;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 1025;
    localparam int PAUSE_AT    = 400;
    localparam int HOLD_AFTER  = 500;
    localparam int HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam int TAIL_CYCLES = 100;

    // Command codes the block does not use; they must answer ok and change nothing.
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

    localparam logic [DATA_W-1:0] READ_FAIL = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN   = 32'h8000_0000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } list_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   rd;
        logic [STATUS_W-1:0] st;
        logic [COUNT_W-1:0]  cnt;
    } list_result_t;

    typedef struct packed {
        list_cmd_t    cmd;
        logic         typed;
        list_result_t res;
    } step_row_t;

    typedef enum {GROW, SHRINK, CHURN} fill_trend_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [47:0]         s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [47:0]         m_tdata;

    // Shadow copy of the list and the results still owed by the block.
    logic [DATA_W-1:0]   shadow_list [CAP];
    int unsigned         shadow_len = 0;
    list_result_t        expected_q [$];
    int                  errors = 0;
    int                  results_seen = 0;
    int                  burst_left = 0;
    fill_trend_t         trend = GROW;

    // Directed commands, starting from an empty list after reset.
    step_row_t step_table [DIR_ROWS] = '{
        '{'{FN_RD_FRONT, 7'd0,   32'd0},        1'b1, '{READ_FAIL, ST_EMPTY,  7'd0}},
        '{'{FN_RD_BACK,  7'd0,   32'd0},        1'b1, '{READ_FAIL, ST_EMPTY,  7'd0}},
        '{'{FN_RD_AT,    7'd0,   32'd0},        1'b1, '{READ_FAIL, ST_EMPTY,  7'd0}},
        '{'{FN_RM_FRONT, 7'd0,   32'd0},        1'b1, '{32'd0,     ST_EMPTY,  7'd0}},
        '{'{FN_RM_BACK,  7'd0,   32'd0},        1'b1, '{32'd0,     ST_EMPTY,  7'd0}},
        '{'{FN_RM_AT,    7'd0,   32'd0},        1'b1, '{32'd0,     ST_EMPTY,  7'd0}},
        '{'{FN_INS_AT,   7'd1,   32'h1234},     1'b1, '{32'd0,     ST_BADPOS, 7'd0}},
        '{'{FN_INS_FRONT, 7'd0,  VAL_MAX},      1'b1, '{32'd0,     ST_OK,     7'd1}},
        '{'{FN_INS_BACK, 7'd0,   VAL_MIN},      1'b1, '{32'd0,     ST_OK,     7'd2}},
        '{'{FN_INS_AT,   7'd2,   READ_FAIL},    1'b1, '{32'd0,     ST_OK,     7'd3}},
        '{'{FN_INS_AT,   7'd0,   32'd0},        1'b0, '0},
        '{'{FN_INS_AT,   7'd2,   32'h5A5A_5A5A}, 1'b0, '0},
        '{'{FN_RD_FRONT, 7'd0,   32'd0},        1'b1, '{32'd0,     ST_OK,     7'd5}},
        '{'{FN_RD_BACK,  7'd0,   32'd0},        1'b1, '{READ_FAIL, ST_OK,     7'd5}},
        '{'{FN_RD_AT,    7'd1,   32'd0},        1'b1, '{VAL_MAX,   ST_OK,     7'd5}},
        '{'{FN_RD_AT,    7'd64,  32'd0},        1'b1, '{READ_FAIL, ST_BADPOS, 7'd5}},
        '{'{FN_RD_AT,    7'd5,   32'd0},        1'b1, '{READ_FAIL, ST_BADPOS, 7'd5}},
        '{'{FN_RM_AT,    7'd127, 32'd0},        1'b1, '{32'd0,     ST_BADPOS, 7'd5}},
        '{'{FN_SPARE_LO, 7'd0,   32'h1234},     1'b1, '{32'd0,     ST_OK,     7'd5}},
        '{'{FN_SPARE_HI, 7'd127, READ_FAIL},    1'b1, '{32'd0,     ST_OK,     7'd5}},
        '{'{FN_RM_AT,    7'd5,   32'd0},        1'b1, '{32'd0,     ST_BADPOS, 7'd5}},
        '{'{FN_RM_AT,    7'd2,   32'd0},        1'b0, '0},
        '{'{FN_RM_FRONT, 7'd0,   32'd0},        1'b0, '0},
        '{'{FN_RM_BACK,  7'd0,   32'd0},        1'b0, '0},
        '{'{FN_RD_AT,    7'd1,   32'd0},        1'b1, '{VAL_MIN,   ST_OK,     7'd2}}
    };

    positional_list_store_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Shadow list operations; each returns the status the block should report.
    function automatic logic [STATUS_W-1:0] shadow_insert(int unsigned where,
                                                          logic [DATA_W-1:0] v);
        if (where > shadow_len) return ST_BADPOS;
        if (shadow_len >= CAP) return ST_FULL;
        for (int unsigned i = shadow_len; i > where; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[where] = v;
        shadow_len++;
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] shadow_remove(int unsigned where);
        if (shadow_len == 0) return ST_EMPTY;
        if (where >= shadow_len) return ST_BADPOS;
        for (int unsigned i = where; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
        shadow_len--;
        return ST_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] shadow_read(int unsigned where,
                                                        output logic [DATA_W-1:0] v);
        v = READ_FAIL;
        if (shadow_len == 0) return ST_EMPTY;
        if (where >= shadow_len) return ST_BADPOS;
        v = shadow_list[where];
        return ST_OK;
    endfunction

    // Applies one command to the shadow list and returns the result it owes.
    function automatic list_result_t apply_list_cmd(list_cmd_t c);
        list_result_t r;
        int unsigned  last;
        r.rd = '0;
        r.st = ST_OK;
        last = (shadow_len == 0) ? 0 : shadow_len - 1;
        case (c.func)
            FN_INS_FRONT: r.st = shadow_insert(0, c.val);
            FN_INS_BACK:  r.st = shadow_insert(shadow_len, c.val);
            FN_INS_AT:    r.st = shadow_insert(c.pos, c.val);
            FN_RD_FRONT:  r.st = shadow_read(0, r.rd);
            FN_RD_BACK:   r.st = shadow_read(last, r.rd);
            FN_RD_AT:     r.st = shadow_read(c.pos, r.rd);
            FN_RM_FRONT:  r.st = shadow_remove(0);
            FN_RM_BACK:   r.st = shadow_remove(last);
            FN_RM_AT:     r.st = shadow_remove(c.pos);
            default:      ;
        endcase
        r.cnt = COUNT_W'(shadow_len);
        return r;
    endfunction

    // Random command; the trend swings the list between empty and full.
    function automatic list_cmd_t pick_list_cmd();
        list_cmd_t   c;
        int unsigned roll;
        int unsigned ins_w;
        int unsigned kind;
        bit          bad_pos;
        case (trend)
            GROW:    ins_w = 65;
            SHRINK:  ins_w = 15;
            default: ins_w = 35;
        endcase
        roll    = $urandom_range(99);
        kind    = $urandom_range(2);
        bad_pos = ($urandom_range(99) < 15);
        c.pos   = POS_W'($urandom_range(127));
        c.val   = ($urandom_range(9) == 0) ? ((($urandom_range(3) == 0) ? VAL_MAX :
                  ($urandom_range(2) == 0) ? VAL_MIN : ($urandom_range(1) == 0) ? 32'd0 :
                  READ_FAIL)) : $urandom;
        if (roll < 2) begin
            c.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        end else if (roll < 2 + ins_w) begin
            c.func = (kind == 0) ? FN_INS_FRONT : (kind == 1) ? FN_INS_BACK : FN_INS_AT;
            if (c.func == FN_INS_AT)
                c.pos = bad_pos ? POS_W'($urandom_range(127, shadow_len + 1))
                                : POS_W'($urandom_range(shadow_len));
        end else begin
            if (roll < 27 + ins_w)
                c.func = (kind == 0) ? FN_RD_FRONT : (kind == 1) ? FN_RD_BACK : FN_RD_AT;
            else
                c.func = (kind == 0) ? FN_RM_FRONT : (kind == 1) ? FN_RM_BACK : FN_RM_AT;
            if (c.func == FN_RD_AT || c.func == FN_RM_AT)
                c.pos = (bad_pos || shadow_len == 0) ? POS_W'($urandom_range(127, shadow_len))
                                                     : POS_W'($urandom_range(shadow_len - 1));
        end
        return c;
    endfunction

    // Offers one command, waits for its transfer, then books the result it owes.
    task automatic issue_cmd(input list_cmd_t c, input logic typed, input list_result_t res);
        list_result_t owed;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, c.val, c.pos, c.func};
        do @(posedge aclk); while (!s_tready);
        owed = apply_list_cmd(c);
        expected_q.push_back(typed ? res : owed);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(0, 20);
        end
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_results_drained();
        if (s_tvalid) s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            errors++;
        end
    endtask

    // Compares each result transfer with the oldest owed result.
    always @(posedge aclk) begin : result_check
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.rd  = m_tdata[31:0];
            got.st  = m_tdata[33:32];
            got.cnt = m_tdata[40:34];
            results_seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none expected, got read_value %h status %0d count %0d",
                         $time, got.rd, got.st, got.cnt);
                errors++;
            end else begin
                want = expected_q.pop_front();
                check_field("read_value", want.rd, got.rd);
                check_field("status", 32'(want.st), 32'(got.st));
                check_field("count", 32'(want.cnt), 32'(got.cnt));
            end
        end
    end

    // Receiver: rotating stall patterns, plus one long hold-off so the block backs up.
    initial begin : result_sink
        logic [15:0] stall_pat;
        int          run_left;
        bit          held;
        stall_pat = '1;
        run_left  = 0;
        held      = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (run_left == 0) begin
                    stall_pat = ($urandom_range(2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
                    run_left  = $urandom_range(16, 200);
                end
                m_tready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
                run_left--;
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin : stall_watch
        int idle_cycles;
        idle_cycles = 0;
        @(posedge aclk iff aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("tb_positional_list_store_top: errors");
        $finish;
    end

    // Main sequence: reset, directed table, random commands, drain and verdict.
    initial begin : stimulus
        list_cmd_t c;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            issue_cmd(step_table[i].cmd, step_table[i].typed, step_table[i].res);
        wait_results_drained();

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == PAUSE_AT) wait_results_drained();
            // Swing direction at the extremes; churn now and then.
            if (trend == GROW && shadow_len == CAP && $urandom_range(3) == 0) trend = SHRINK;
            else if (trend == SHRINK && shadow_len == 0 && $urandom_range(3) == 0)
                trend = ($urandom_range(2) == 0) ? CHURN : GROW;
            else if (trend == CHURN && $urandom_range(49) == 0) trend = GROW;
            c = pick_list_cmd();
            issue_cmd(c, 1'b0, '0);
        end
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0 && expected_q.size() == 0)
            $display("tb_positional_list_store_top: clean");
        else
            $display("tb_positional_list_store_top: errors");
        $finish;
    end

endmodule

`default_nettype wire
